// ===== rtl/core/c2e_pkg.sv =====
// Shared types, register indexes and the month table of the calendar-to-epoch converter.
package c2e_pkg;

    localparam int unsigned CfgIndexWidth = 2;

    localparam logic [CfgIndexWidth-1:0] CFG_ZONE_OFFSET     = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_VALID_THRESHOLD = 2'd1;

    localparam logic [16:0] ZONE_OFFSET_RESET     = 17'd19800;
    localparam logic [31:0] VALID_THRESHOLD_RESET = 32'd1693542216;

    localparam logic [11:0] EPOCH_YEAR = 12'd1970;

    typedef struct packed {
        logic [11:0] calendar_year;
        logic [3:0]  calendar_month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour_of_day;
        logic [5:0]  minute_of_hour;
        logic [5:0]  second_of_minute;
    } t_cal_req;

    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic [16:0] seconds_of_day;
        logic [4:0]  day_out;
        logic        time_valid;
    } t_epoch_res;

    // Day count and time-of-day handed from the day counter to the seconds stages
    typedef struct packed {
        logic [31:0] total_days;
        logic [16:0] seconds_of_day;
        logic [4:0]  day_of_month;
    } t_day_info;

    // Days before the first of a month in a common year; month is 1-based
    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] days;
        unique case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

// ===== rtl/core/calendar_to_epoch_seconds_unit.sv =====
// Top level of the calendar-to-epoch converter: request channel, register port and seconds stages.
//
// Usage:
//   Request channel: drive i_req with a calendar time and raise i_start; the request is
//   taken at any clock edge with i_start high and o_busy low. o_busy never rises, so a
//   new request may be issued every cycle.
//   Result channel: o_res_valid marks o_res for exactly one cycle; the receiver cannot
//   hold results off and must take each one as it appears.
//   Pipeline: a request taken at a clock edge passes through the two day-count stages,
//   a 32x17 product by 86400, the final add and the threshold compare, and its result
//   is strobed from the last stage's register. Throughput is one request per cycle, set
//   by the five-stage pipeline.
//   Register port: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data. Index 0
//   is the signed 17-bit zone offset (low bits of the data), index 1 the 32-bit valid
//   threshold; other indexes are ignored. Write only while no request is in flight.
//   Reset (synchronous, active low): clears the pipeline valid bits and restores the
//   zone offset to 19800 s and the threshold to 1693542216.
module calendar_to_epoch_seconds_unit
    import c2e_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  t_cal_req                 i_req,
    output logic                     o_res_valid,
    output t_epoch_res               o_res,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CfgIndexWidth-1:0] i_cfg_index,
    input  logic [31:0]              i_cfg_data
);

    logic        zone_sign;
    logic [16:0] r_zone;
    logic [31:0] r_threshold;

    logic        req_take;
    logic        day_valid;
    t_day_info   day_info;

    logic        r_v3;
    logic [31:0] r_day_secs;
    logic [31:0] r_sod_adj;
    logic [16:0] r_sod3;
    logic [4:0]  r_day3;

    logic        r_v4;
    logic [31:0] r_epoch;
    logic [16:0] r_sod4;
    logic [4:0]  r_day4;

    logic        r_v5;
    t_epoch_res  r_res;

    // The pipeline never stalls: accept every request and every register write
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign req_take    = i_start && !o_busy;

    // Register file; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone      <= ZONE_OFFSET_RESET;
            r_threshold <= VALID_THRESHOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ZONE_OFFSET:     r_zone      <= i_cfg_data[16:0];
                CFG_VALID_THRESHOLD: r_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sign bit of the zone offset, for extension to 32 bits
    assign zone_sign = r_zone[16];

    c2e_day_count u_day_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (req_take),
        .i_req   (i_req),
        .o_valid (day_valid),
        .o_info  (day_info)
    );

    // Stage 3: scale the day count to seconds, fold the zone offset into seconds of day
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= day_valid;
        end
        r_day_secs <= day_info.total_days * 32'd86400;
        r_sod_adj  <= 32'(day_info.seconds_of_day) - {{15{zone_sign}}, r_zone};
        r_sod3     <= day_info.seconds_of_day;
        r_day3     <= day_info.day_of_month;
    end

    // Stage 4: wrap-around sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_epoch <= r_day_secs + r_sod_adj;
        r_sod4  <= r_sod3;
        r_day4  <= r_day3;
    end

    // Stage 5: threshold compare and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        r_res.epoch_seconds  <= r_epoch;
        r_res.seconds_of_day <= r_sod4;
        r_res.day_out        <= r_day4;
        r_res.time_valid     <= (r_epoch >= r_threshold);
    end

    assign o_res_valid = r_v5;
    assign o_res       = r_res;

`ifndef SYNTHESIS
    // Every accepted request gives its result once it has passed through the pipeline
    a_req_to_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take |-> ##5 o_res_valid)
        else $error("request did not produce a result after five cycles");

    // A result only appears for a request that was taken earlier
    a_res_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(req_take, 5))
        else $error("result strobe without a matching request");

    // The day of month travels unchanged alongside its request
    a_day_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.day_out == $past(i_req.day_of_month, 5)))
        else $error("day of month out of step with its request");
`endif

endmodule

// ===== rtl/core/c2e_day_count.sv =====
// Two-stage day counter: clamped calendar date to days since 1970 plus seconds of day.
module c2e_day_count
    import c2e_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cal_req  i_req,
    output logic      o_valid,
    output t_day_info o_info
);

    // Leap days through 1969: 492 - 19 + 4
    localparam logic [10:0] LEAPS_TO_EPOCH = 11'd477;

    logic [11:0] year_c;
    logic [3:0]  month_c;
    logic [11:0] year_off;
    logic [11:0] year_prev;

    logic        r_v1;
    logic [20:0] r_year_days;
    logic [9:0]  r_prev_q4;
    logic [15:0] r_prev_q4x41;
    logic [9:0]  r_year_q4;
    logic [15:0] r_year_q4x41;
    logic        r_year_mod4_zero;
    logic        r_after_feb;
    logic [8:0]  r_month_days;
    logic [4:0]  r_day;
    logic [16:0] r_sod;

    logic [5:0]  prev_q100;
    logic [3:0]  prev_q400;
    logic [5:0]  year_q100;
    logic        year_mod100_zero;
    logic        year_is_leap;
    logic [10:0] leaps;
    logic [31:0] n_days;

    logic        r_v2;
    t_day_info   r_info;

    always_comb begin
        year_c  = (i_req.calendar_year < EPOCH_YEAR) ? EPOCH_YEAR : i_req.calendar_year;
        month_c = i_req.calendar_month;
        if (month_c == 4'd0) begin
            month_c = 4'd1;
        end else if (month_c > 4'd12) begin
            month_c = 4'd12;
        end
        year_off  = year_c - EPOCH_YEAR;
        year_prev = year_c - 12'd1;
    end

    // Stage 1: year-length product, quarter-year counts and their /25 reciprocals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_year_days      <= 21'(year_off) * 21'd365;
        r_prev_q4        <= year_prev[11:2];
        r_prev_q4x41     <= 16'(year_prev[11:2]) * 16'd41;
        r_year_q4        <= year_c[11:2];
        r_year_q4x41     <= 16'(year_c[11:2]) * 16'd41;
        r_year_mod4_zero <= (year_c[1:0] == 2'd0);
        r_after_feb      <= (month_c > 4'd2);
        r_month_days     <= days_before_month(month_c);
        r_day            <= i_req.day_of_month;
        r_sod            <= 17'(i_req.hour_of_day) * 17'd3600
                          + 17'(i_req.minute_of_hour) * 17'd60
                          + 17'(i_req.second_of_minute);
    end

    // x*41 >> 10 is exact floor(x/25) for x below 1024
    always_comb begin
        prev_q100        = r_prev_q4x41[15:10];
        prev_q400        = prev_q100[5:2];
        year_q100        = r_year_q4x41[15:10];
        year_mod100_zero = r_year_mod4_zero && (r_year_q4 == 10'(year_q100) * 10'd25);
        year_is_leap     = r_year_mod4_zero && (!year_mod100_zero || (year_q100[1:0] == 2'd0));
        leaps            = 11'(r_prev_q4) - 11'(prev_q100) + 11'(prev_q400) - LEAPS_TO_EPOCH;
        // Day zero wraps to minus one day, as the count is taken modulo 2^32
        n_days           = 32'(r_year_days) + 32'(leaps) + 32'(r_month_days)
                         + 32'(year_is_leap && r_after_feb) + 32'(r_day) - 32'd1;
    end

    // Stage 2: total day count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_info.total_days     <= n_days;
        r_info.seconds_of_day <= r_sod;
        r_info.day_of_month   <= r_day;
    end

    assign o_valid = r_v2;
    assign o_info  = r_info;

endmodule

// ===== tb/calendar_to_epoch_seconds_unit_tb.sv =====
// Self-checking testbench of the calendar-to-epoch converter: directed and random requests.
`timescale 1ns / 100ps

module calendar_to_epoch_seconds_unit_tb
    import c2e_pkg::*;
();

    // Spare register indexes: the block must ignore writes to them
    localparam logic [CfgIndexWidth-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_SPARE_3 = 2'd3;

    localparam int unsigned RANDOM_PHASES   = 6;
    localparam int unsigned ITEMS_PER_PHASE = 135;
    // Idle cycles added after the last expected result has come back
    localparam int unsigned PIPE_DRAIN      = 10;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned REPORT_LIMIT    = 10;

    // Days before the first of each month in a common year, January first
    localparam int unsigned MONTH_START_DAY [12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    // Holds the register copies and the queue of expected epoch results
    class epoch_scoreboard;
        logic [16:0] zone_offset;
        logic [31:0] valid_threshold;
        t_epoch_res  expected_q [$];
        int unsigned mismatches;

        function new();
            zone_offset     = ZONE_OFFSET_RESET;
            valid_threshold = VALID_THRESHOLD_RESET;
            mismatches      = 0;
        endfunction

        function void apply_register(logic [CfgIndexWidth-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_ZONE_OFFSET:     zone_offset = data[16:0];
                CFG_VALID_THRESHOLD: valid_threshold = data;
                default: ;
            endcase
        endfunction

        function int unsigned leaps_upto(int unsigned y);
            return y / 4 - y / 100 + y / 400;
        endfunction

        // Gregorian calendar time to zone-adjusted epoch seconds, wrapping at 32 bits
        function t_epoch_res convert(t_cal_req r);
            int unsigned     year;
            int unsigned     month;
            longint unsigned days;
            logic [31:0]     sod;
            logic [31:0]     epoch;
            t_epoch_res      res;
            year  = (r.calendar_year < EPOCH_YEAR) ? EPOCH_YEAR : r.calendar_year;
            month = (r.calendar_month == 0) ? 1 :
                    (r.calendar_month > 12) ? 12 : r.calendar_month;
            days  = (year - EPOCH_YEAR) * 365 + leaps_upto(year - 1)
                  - leaps_upto(EPOCH_YEAR - 1);
            days += MONTH_START_DAY[month - 1];
            if (month > 2 && (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0)))
                days += 1;
            sod   = r.hour_of_day * 3600 + r.minute_of_hour * 60 + r.second_of_minute;
            epoch = 32'(days * 64'd86400);
            epoch += (32'(r.day_of_month) - 32'd1) * 32'd86400;
            epoch += sod;
            epoch -= {{15{zone_offset[16]}}, zone_offset};
            res.epoch_seconds  = epoch;
            res.seconds_of_day = sod[16:0];
            res.day_out        = r.day_of_month;
            res.time_valid     = (epoch >= valid_threshold);
            return res;
        endfunction

        function void note_request(t_cal_req r);
            expected_q.push_back(convert(r));
        endfunction

        function void check_result(t_epoch_res got);
            t_epoch_res want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: epoch %0d sod %0d day %0d valid %0d",
                             got.epoch_seconds, got.seconds_of_day, got.day_out,
                             got.time_valid);
                return;
            end
            want = expected_q.pop_front();
            if (got.epoch_seconds  !== want.epoch_seconds  ||
                got.seconds_of_day !== want.seconds_of_day ||
                got.day_out        !== want.day_out        ||
                got.time_valid     !== want.time_valid) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: epoch %0d/%0d sod %0d/%0d day %0d/%0d valid %0d/%0d",
                             want.epoch_seconds, got.epoch_seconds,
                             want.seconds_of_day, got.seconds_of_day,
                             want.day_out, got.day_out, want.time_valid, got.time_valid);
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    t_cal_req                 req;
    logic                     res_valid;
    t_epoch_res               res;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [31:0]              cfg_data;

    epoch_scoreboard sb;
    int unsigned     cycle_count = 0;
    bit              idling;

    calendar_to_epoch_seconds_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_req       (req),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 4 ns clock: 2 ns high, 2 ns low
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Sample both channels at the edge: a request is taken with start high and busy low,
    // and a strobed result is taken at the edge that ends its cycle.
    always @(posedge clk) begin
        if (rst_n && start && !busy)
            sb.note_request(req);
        if (rst_n && res_valid)
            sb.check_result(res);
    end

    // Watchdog: give up well beyond the slowest correct run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("calendar_to_epoch_seconds_unit_tb NOT OK");
            $finish;
        end
    end

    function automatic t_cal_req make_request(int unsigned y, int unsigned mo, int unsigned d,
                                              int unsigned h, int unsigned mi,
                                              int unsigned s);
        t_cal_req r;
        r.calendar_year    = 12'(y);
        r.calendar_month   = 4'(mo);
        r.day_of_month     = 5'(d);
        r.hour_of_day      = 5'(h);
        r.minute_of_hour   = 6'(mi);
        r.second_of_minute = 6'(s);
        return r;
    endfunction

    // Mostly well-formed dates; now and then raw bits across every field
    function automatic t_cal_req random_request();
        t_cal_req r;
        if ($urandom_range(0, 99) < 15) begin
            r.calendar_year    = 12'($urandom);
            r.calendar_month   = 4'($urandom);
            r.day_of_month     = 5'($urandom);
            r.hour_of_day      = 5'($urandom);
            r.minute_of_hour   = 6'($urandom);
            r.second_of_minute = 6'($urandom);
        end else begin
            r = make_request($urandom_range(1970, 2105), $urandom_range(1, 12),
                             $urandom_range(1, 31), $urandom_range(0, 23),
                             $urandom_range(0, 59), $urandom_range(0, 59));
        end
        return r;
    endfunction

    // Zone offset in the low 17 bits; junk above, which the block must drop
    function automatic logic [31:0] zone_word(int seconds);
        return {15'($urandom), 17'(seconds)};
    endfunction

    // Present one request and hold it until the block takes it; leave start high so a
    // following request can go out back to back, save that idling phases now and then drop start.
    task automatic send_request(input t_cal_req r);
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        if (idling && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            req   <= random_request();
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic write_register(input logic [CfgIndexWidth-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.apply_register(idx, data);
        // Hold the channel idle before the next write
        @(posedge clk);
    endtask

    // Drop start and wait until every expected result has come back
    task automatic drain_pipeline();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    initial begin
        t_cal_req   pivot;
        t_epoch_res pivot_res;
        sb          = new();
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        idling      = 1'b1;

        // Hold reset, then release it for good
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset registers: epoch origin, saturated years,
        // clamped months, day zero, leap and non-leap centuries, all-ones fields
        send_request(make_request(1970, 1, 1, 0, 0, 0));
        send_request(make_request(0, 1, 1, 0, 0, 0));
        send_request(make_request(1969, 12, 31, 23, 59, 59));
        send_request(make_request(1600, 3, 1, 0, 0, 0));
        send_request(make_request(4095, 15, 31, 31, 63, 63));
        send_request(make_request(2105, 12, 31, 23, 59, 59));
        send_request(make_request(2000, 2, 29, 12, 0, 0));
        send_request(make_request(2000, 3, 1, 0, 0, 0));
        send_request(make_request(2100, 3, 1, 0, 0, 0));
        send_request(make_request(2104, 3, 1, 0, 0, 0));
        send_request(make_request(2400, 12, 31, 0, 0, 0));
        send_request(make_request(3000, 7, 4, 1, 2, 3));
        send_request(make_request(2024, 0, 15, 8, 30, 0));
        send_request(make_request(2024, 13, 15, 8, 30, 0));
        send_request(make_request(2023, 6, 0, 6, 6, 6));
        send_request(make_request(1970, 1, 0, 0, 0, 0));
        send_request(make_request(2038, 1, 19, 3, 14, 7));
        // Either side of the reset threshold once the reset zone offset is taken off
        send_request(make_request(2023, 9, 1, 9, 53, 35));
        send_request(make_request(2023, 9, 1, 9, 53, 36));
        send_request(make_request(2023, 9, 1, 9, 53, 37));
        for (int m = 1; m <= 12; m++)
            send_request(make_request(2021, m, 28, 0, 0, 0));
        drain_pipeline();

        // Threshold set exactly on one conversion: probe one second either side
        write_register(CFG_ZONE_OFFSET, zone_word(0));
        pivot     = make_request(2038, 1, 19, 3, 14, 8);
        pivot_res = sb.convert(pivot);
        write_register(CFG_VALID_THRESHOLD, pivot_res.epoch_seconds);
        send_request(make_request(2038, 1, 19, 3, 14, 7));
        send_request(pivot);
        send_request(make_request(2038, 1, 19, 3, 14, 9));
        drain_pipeline();

        // Random phases, each under its own register setting; the last runs flat out
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    write_register(CFG_ZONE_OFFSET, zone_word(-50400));
                    write_register(CFG_VALID_THRESHOLD, 32'd0);
                end
                1: begin
                    write_register(CFG_ZONE_OFFSET, zone_word(50400));
                    write_register(CFG_VALID_THRESHOLD, 32'hFFFF_FFFF);
                end
                2: begin
                    write_register(CFG_SPARE_2, $urandom);
                    write_register(CFG_SPARE_3, $urandom);
                    write_register(CFG_ZONE_OFFSET, zone_word($urandom_range(0, 100800) - 50400));
                    write_register(CFG_VALID_THRESHOLD, $urandom);
                end
                3: begin
                    // Most negative 17-bit offset, beyond the usual range; phase 4 takes the most positive
                    write_register(CFG_ZONE_OFFSET, zone_word(-65536));
                    write_register(CFG_VALID_THRESHOLD, 32'h8000_0000);
                end
                4: begin
                    write_register(CFG_ZONE_OFFSET, zone_word(65535));
                    write_register(CFG_VALID_THRESHOLD, $urandom_range(946684800, 4102444800));
                end
                default: begin
                    write_register(CFG_ZONE_OFFSET, $urandom);
                    write_register(CFG_VALID_THRESHOLD, VALID_THRESHOLD_RESET);
                end
            endcase
            idling = (phase < RANDOM_PHASES - 1);
            repeat (ITEMS_PER_PHASE) send_request(random_request());
            drain_pipeline();
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("calendar_to_epoch_seconds_unit_tb OK");
        end else begin
            $display("calendar_to_epoch_seconds_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
